// ===== hw/rtl/tpr_pkg.sv =====
// Package for the two-pole resonator: widths, fixed-point constants,
// multiplier mode codes and the multiplier request struct.
// No dependencies.
package tpr_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int HIST_W      = 32;
  localparam int FREQ_W      = 18;
  localparam int DECAY_W     = 16;
  localparam int RATE_W      = 18;
  localparam int OUT_W       = 23;
  localparam int COEF_W      = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;

  localparam logic signed [63:0] OUT_LIMIT = 64'sd2621440;
  localparam logic signed [OUT_W-1:0] OUT_HI = 23'sd2621440;
  localparam logic signed [OUT_W-1:0] OUT_LO = -23'sd2621440;

  localparam logic signed [63:0] HIST_MAX = 64'sd2 ** (HIST_W - 1) - 64'sd1;
  localparam logic signed [63:0] HIST_MIN = -HIST_MAX - 64'sd1;

  // multiplier modes
  localparam logic [1:0] MUL_Q60 = 2'd0;  // unsigned, (a*b) >> 60
  localparam logic [1:0] MUL_S30 = 2'd1;  // signed, rounded half away, >> 30
  localparam logic [1:0] MUL_S31 = 2'd2;  // signed, rounded half away, >> 31

  typedef struct packed {
    logic       start;
    logic [1:0] mode;
  } mul_req_t;

endpackage

// ===== hw/rtl/two_pole_resonator.sv =====
// Two-pole resonator top level: sequencer, coefficient and history state,
// and the stream ports. Uses tpr_pkg, tpr_mul and tpr_div.
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   sample_in, freq_q4, decay_q12
//  m_*       out        m_tvalid / m_tready   sample_out
//  cfg_*     in         cfg_valid / cfg_ready sample_rate
//
// An item with an unchanged frequency/decay pair runs, between one input
// transfer and the next, through the accepting cycle, three passes through the
// shared multiplier (four 32x32 partial products each) and a hand-over in
// ST_DONE. A recompute adds the divider work (about 80 to 110 divisions for
// the series) and a 32-step square root. Reset is synchronous; it restores
// 48 kHz and forces a recompute on the first item. One item is in work at a
// time; a finished result waits in the output register while the next item is
// accepted.
module two_pole_resonator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // sample_in [23:0], freq_q4 [41:24], decay_q12 [57:42], zero fill above
  input  logic [tpr_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // sample_out [22:0], zero fill above
  output logic [tpr_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tpr_pkg::RATE_W-1:0]       cfg_data
);
  import tpr_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_AT_U    = 5'd1;
  localparam logic [4:0] ST_AT_U2   = 5'd2;
  localparam logic [4:0] ST_AT_DIV  = 5'd3;
  localparam logic [4:0] ST_AT_MUL  = 5'd4;
  localparam logic [4:0] ST_EX_A    = 5'd5;
  localparam logic [4:0] ST_EX_N    = 5'd6;
  localparam logic [4:0] ST_EX_MUL  = 5'd7;
  localparam logic [4:0] ST_EX_DIV  = 5'd8;
  localparam logic [4:0] ST_R2      = 5'd9;
  localparam logic [4:0] ST_PH_DIV  = 5'd10;
  localparam logic [4:0] ST_PH_X    = 5'd11;
  localparam logic [4:0] ST_CS_X2   = 5'd12;
  localparam logic [4:0] ST_CS_MUL  = 5'd13;
  localparam logic [4:0] ST_CS_DIV  = 5'd14;
  localparam logic [4:0] ST_B1_MUL  = 5'd15;
  localparam logic [4:0] ST_B1_DIV  = 5'd16;
  localparam logic [4:0] ST_GN_DIV  = 5'd17;
  localparam logic [4:0] ST_GN_SQRT = 5'd18;
  localparam logic [4:0] ST_F_S1    = 5'd19;
  localparam logic [4:0] ST_F_S2    = 5'd20;
  localparam logic [4:0] ST_F_OUT   = 5'd21;
  localparam logic [4:0] ST_DONE    = 5'd22;

  localparam logic [39:0] HALF_TURN = 40'h80_0000_0000;
  localparam logic [39:0] QTR_TURN  = 40'h40_0000_0000;

  logic [4:0]  state;
  logic        pend;

  // architectural state
  logic [RATE_W-1:0]         sample_rate;
  logic signed [HIST_W-1:0]  hist_one, hist_two;
  logic [COEF_W-1:0]         coef_fb1, coef_fb2, out_gain;
  logic [FREQ_W-1:0]         last_freq;
  logic [DECAY_W-1:0]        last_decay;
  logic                      coefs_valid;

  // current item
  logic [SAMPLE_W-1:0] x_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [DECAY_W-1:0]  decay_r;

  // working registers
  logic        at_sel;
  logic [5:0]  k;
  logic [5:0]  nsh;
  logic [63:0] term, sum, u2, ln2, lnk, xa, rr, r, r2, x2;
  logic [39:0] t;
  logic        neg;
  logic [63:0] sq_n, sq_res, sq_bit;
  logic [63:0] s1;
  logic signed [HIST_W-1:0] y0;
  logic [OUT_W-1:0] out_r, o_res;

  // unit ports
  mul_req_t    mul_req;
  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_done;
  logic        div_start, div_done;
  logic [63:0] div_hi, div_lo, div_den, div_q, div_r;

  // helpers
  logic [RATE_W-1:0] fs;
  logic              s_fire, cfg_fire, recompute, udone;
  logic [33:0]       dfs;
  logic [26:0]       g_num;
  logic [31:0]       g_den;
  logic [6:0]        k2, k2m1;
  logic [13:0]       cs_den;
  logic [63:0]       sum_step, sum_abs;
  logic [39:0]       t0, t1, t_fold;
  logic              neg_fold;
  logic [63:0]       sq_trial, sq_res_next;
  logic              sq_ge;
  logic signed [63:0] y_sum, y_sat, o_full, o_clamp;
  logic [63:0]       b1_mag, g_rnd, fb2_rnd;

  assign fs        = (sample_rate == '0) ? RATE_W'(1) : sample_rate;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign recompute = !coefs_valid || cfg_fire
                   || (s_tdata[41:24] != last_freq) || (s_tdata[57:42] != last_decay);
  assign udone     = mul_done || div_done;
  assign m_tdata   = {1'b0, out_r};

  assign dfs    = 34'(decay_r) * 34'(fs);
  assign g_num  = 27'(fs) * 27'd288;
  assign g_den  = 32'(freq_r) * 32'd10000 + 32'(fs) * 32'd800;
  assign k2     = {k, 1'b0};
  assign k2m1   = k2 - 7'd1;
  assign cs_den = 14'(k2m1) * 14'(k2);

  // odd terms subtract, even terms add (exp and cos series alike)
  assign sum_step = k[0] ? (sum - div_q) : (sum + div_q);
  assign sum_abs  = sum_step[63] ? (64'd0 - sum_step) : sum_step;

  // fold the phase (Q40 turns) into the first quadrant
  always_comb begin
    t0       = div_q[39:0];
    t1       = (t0 > HALF_TURN) ? (40'd0 - t0) : t0;
    neg_fold = (t1 > QTR_TURN);
    t_fold   = neg_fold ? (HALF_TURN - t1) : t1;
  end

  assign sq_trial    = sq_res + sq_bit;
  assign sq_ge       = (sq_n >= sq_trial);
  assign sq_res_next = sq_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
  assign g_rnd       = sq_res_next + 64'd1;

  assign b1_mag  = div_q + 64'd1;
  assign fb2_rnd = r2 + (64'd1 << 29);

  always_comb begin
    y_sum = 64'($signed(x_r)) + $signed(s1) + $signed(mul_res);
    if (y_sum > HIST_MAX)      y_sat = HIST_MAX;
    else if (y_sum < HIST_MIN) y_sat = HIST_MIN;
    else                       y_sat = y_sum;
    o_full = $signed(mul_res);
    if (o_full > OUT_LIMIT)       o_clamp = OUT_LIMIT;
    else if (o_full < -OUT_LIMIT) o_clamp = -OUT_LIMIT;
    else                          o_clamp = o_full;
  end

  // operand selection for the shared units
  always_comb begin
    logic is_mul, is_div;
    is_mul       = 1'b0;
    is_div       = 1'b0;
    mul_req.mode = MUL_Q60;
    mul_a        = '0;
    mul_b        = '0;
    div_hi       = '0;
    div_lo       = '0;
    div_den      = 64'd1;
    case (state)
      ST_AT_U: begin
        is_div  = 1'b1;
        div_lo  = at_sel ? (64'd3 << 60) : ONE_Q60;
        div_den = at_sel ? 64'd253 : 64'd3;
      end
      ST_AT_U2:  begin is_mul = 1'b1; mul_a = term; mul_b = term; end
      ST_AT_DIV: begin is_div = 1'b1; div_lo = term; div_den = 64'({k, 1'b1}); end
      ST_AT_MUL: begin is_mul = 1'b1; mul_a = term; mul_b = u2; end
      ST_EX_A:   begin is_div = 1'b1; div_lo = lnk; div_den = 64'(dfs); end
      ST_EX_N:   begin is_div = 1'b1; div_lo = xa; div_den = ln2 >> 12; end
      ST_EX_MUL: begin is_mul = 1'b1; mul_a = term; mul_b = rr; end
      ST_EX_DIV: begin is_div = 1'b1; div_lo = term; div_den = 64'(k); end
      ST_R2:     begin is_mul = 1'b1; mul_a = r; mul_b = r; end
      ST_PH_DIV: begin
        is_div  = 1'b1;
        div_lo  = {10'd0, freq_r, 36'd0};
        div_den = 64'(fs);
      end
      ST_PH_X:   begin is_mul = 1'b1; mul_a = TWO_PI_Q60; mul_b = {4'd0, t, 20'd0}; end
      ST_CS_X2:  begin is_mul = 1'b1; mul_a = xa; mul_b = xa; end
      ST_CS_MUL: begin is_mul = 1'b1; mul_a = term; mul_b = x2; end
      ST_CS_DIV: begin is_div = 1'b1; div_lo = term; div_den = 64'(cs_den); end
      ST_B1_MUL: begin is_mul = 1'b1; mul_a = {r2[61:0], 2'b00}; mul_b = sum; end
      ST_B1_DIV: begin
        is_div  = 1'b1;
        div_hi  = {33'd0, xa[63:33]};
        div_lo  = {xa[32:0], 31'd0};
        div_den = ONE_Q60 + r2;
      end
      ST_GN_DIV: begin
        is_div  = 1'b1;
        div_hi  = 64'(g_num[26:4]);
        div_lo  = {g_num[3:0], 60'd0};
        div_den = 64'(g_den);
      end
      ST_F_S1: begin
        is_mul = 1'b1; mul_req.mode = MUL_S30;
        mul_a = 64'($signed(coef_fb1)); mul_b = 64'(hist_one);
      end
      ST_F_S2: begin
        is_mul = 1'b1; mul_req.mode = MUL_S30;
        mul_a = 64'($signed(coef_fb2)); mul_b = 64'(hist_two);
      end
      ST_F_OUT: begin
        is_mul = 1'b1; mul_req.mode = MUL_S31;
        mul_a = 64'($signed(out_gain));
        mul_b = 64'(y0) - 64'(hist_two);
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
    mul_req.start = is_mul && !pend;
    div_start     = is_div && !pend;
  end

  tpr_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  tpr_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_hi (div_hi),
    .num_lo (div_lo),
    .den    (div_den),
    .done   (div_done),
    .quot   (div_q),
    .rem    (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pend        <= 1'b0;
      sample_rate <= RATE_RESET;
      hist_one    <= '0;
      hist_two    <= '0;
      coef_fb1    <= '0;
      coef_fb2    <= '0;
      out_gain    <= '0;
      last_freq   <= '0;
      last_decay  <= '0;
      coefs_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // offer a new result once the register is free, drop a transferred one
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      // a rate change invalidates the coefficients
      if (cfg_fire) begin
        sample_rate <= cfg_data;
        coefs_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            x_r     <= s_tdata[23:0];
            freq_r  <= s_tdata[41:24];
            decay_r <= s_tdata[57:42];
            at_sel  <= 1'b0;
            state   <= recompute ? ST_AT_U : ST_F_S1;
          end
        end
        ST_GN_SQRT: begin
          // one root digit a cycle
          if (sq_ge) sq_n <= sq_n - sq_trial;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            out_gain    <= g_rnd[32:1];
            last_freq   <= freq_r;
            last_decay  <= decay_r;
            coefs_valid <= 1'b1;
            state       <= ST_F_S1;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            out_r    <= o_res;
            hist_two <= hist_one;
            hist_one <= y0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          if (!pend) begin
            pend <= 1'b1;
          end else if (udone) begin
            pend <= 1'b0;
            case (state)
              ST_AT_U:   begin term <= div_q; state <= ST_AT_U2; end
              ST_AT_U2:  begin u2 <= mul_res; sum <= '0; k <= '0; state <= ST_AT_DIV; end
              ST_AT_DIV: begin sum <= sum + div_q; state <= ST_AT_MUL; end
              ST_AT_MUL: begin
                term <= mul_res;
                if (k == 6'd31) begin
                  if (!at_sel) begin
                    ln2    <= {sum[62:0], 1'b0};
                    at_sel <= 1'b1;
                    state  <= ST_AT_U;
                  end else begin
                    // ln 1000 = 10 ln2 - 2 atanh(3/253)
                    lnk <= (ln2 << 3) + (ln2 << 1) - {sum[62:0], 1'b0};
                    if (decay_r == '0) begin
                      r     <= '0;
                      state <= ST_R2;
                    end else begin
                      state <= ST_EX_A;
                    end
                  end
                end else begin
                  k     <= k + 6'd1;
                  state <= ST_AT_DIV;
                end
              end
              ST_EX_A: begin xa <= div_q; state <= ST_EX_N; end
              ST_EX_N: begin
                if (div_q < 64'd61) begin
                  nsh   <= div_q[5:0];
                  rr    <= {div_r[51:0], 12'd0};
                  term  <= ONE_Q60;
                  sum   <= ONE_Q60;
                  k     <= 6'd1;
                  state <= ST_EX_MUL;
                end else begin
                  // R below 2^-60: take it as zero
                  r     <= '0;
                  state <= ST_R2;
                end
              end
              ST_EX_MUL: begin term <= mul_res; state <= ST_EX_DIV; end
              ST_EX_DIV: begin
                term <= div_q;
                sum  <= sum_step;
                if (k == 6'd24) begin
                  r     <= sum_step >> nsh;
                  state <= ST_R2;
                end else begin
                  k     <= k + 6'd1;
                  state <= ST_EX_MUL;
                end
              end
              ST_R2:     begin r2 <= mul_res; state <= ST_PH_DIV; end
              ST_PH_DIV: begin t <= t_fold; neg <= neg_fold; state <= ST_PH_X; end
              ST_PH_X:   begin xa <= mul_res; state <= ST_CS_X2; end
              ST_CS_X2: begin
                x2    <= mul_res;
                term  <= ONE_Q60;
                sum   <= ONE_Q60;
                k     <= 6'd1;
                state <= ST_CS_MUL;
              end
              ST_CS_MUL: begin term <= mul_res; state <= ST_CS_DIV; end
              ST_CS_DIV: begin
                term <= div_q;
                if (k == 6'd14) begin
                  sum   <= sum_abs;
                  neg   <= neg ^ sum_step[63];
                  state <= ST_B1_MUL;
                end else begin
                  sum   <= sum_step;
                  k     <= k + 6'd1;
                  state <= ST_CS_MUL;
                end
              end
              ST_B1_MUL: begin xa <= mul_res; state <= ST_B1_DIV; end
              ST_B1_DIV: begin
                coef_fb1 <= neg ? (32'd0 - b1_mag[32:1]) : b1_mag[32:1];
                coef_fb2 <= 32'd0 - fb2_rnd[61:30];
                state    <= ST_GN_DIV;
              end
              ST_GN_DIV: begin
                sq_n   <= {div_q[61:0], 2'b00};
                sq_res <= '0;
                sq_bit <= 64'd1 << 62;
                state  <= ST_GN_SQRT;
              end
              ST_F_S1: begin s1 <= mul_res; state <= ST_F_S2; end
              ST_F_S2: begin y0 <= HIST_W'(y_sat); state <= ST_F_OUT; end
              ST_F_OUT: begin o_res <= o_clamp[OUT_W-1:0]; state <= ST_DONE; end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
      endcase
    end
  end

  // filtering never starts on stale coefficients
  a_coefs_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_F_S1 |-> coefs_valid)
    else $error("filter started without valid coefficients");

  // a unit only reports back to a waiting sequencer
  a_done_pend: assert property (@(posedge clk) disable iff (rst)
    udone |-> pend)
    else $error("unit finished with nothing outstanding");

  // a recompute records the pair it was made for
  a_pair_kept: assert property (@(posedge clk) disable iff (rst)
    $rose(coefs_valid) |-> (last_freq == freq_r) && (last_decay == decay_r))
    else $error("stored pair does not match the recomputed item");

  // offered results stay within the output clamp
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[OUT_W-1:0]) <= OUT_HI)
              && ($signed(m_tdata[OUT_W-1:0]) >= OUT_LO))
    else $error("output outside the clamp range");

endmodule

// ===== hw/rtl/tpr_mul.sv =====
// Shared 64x64 multiplier built from one 32x32 multiplier over four
// partial products, with a selectable shift and rounding. Uses tpr_pkg.
module tpr_mul (
  input  logic              clk,
  input  logic              rst,
  input  tpr_pkg::mul_req_t req,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              done,
  output logic [63:0]       res
);
  import tpr_pkg::*;

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  ua, ub;
  logic         neg;
  logic [1:0]   mode;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [1:0]   pp_off;
  logic [31:0]  a_part, b_part;
  logic [127:0] pp_sh, rounded, rnd_add;
  logic [63:0]  mag;
  logic         sgn_in;

  assign sgn_in = (req.mode != MUL_Q60);
  assign a_part = cnt[1] ? ua[63:32] : ua[31:0];
  assign b_part = cnt[0] ? ub[63:32] : ub[31:0];
  assign pp_sh  = {64'd0, pp} << {pp_off, 5'd0};

  always_comb begin
    case (mode)
      MUL_S30: rnd_add = 128'd1 << 29;
      MUL_S31: rnd_add = 128'd1 << 30;
      default: rnd_add = 128'd0;
    endcase
    rounded = acc + rnd_add;
    case (mode)
      MUL_S30: mag = rounded[93:30];
      MUL_S31: mag = rounded[94:31];
      default: mag = rounded[123:60];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        mode <= req.mode;
        ua   <= (sgn_in && a[63]) ? (64'd0 - a) : a;
        ub   <= (sgn_in && b[63]) ? (64'd0 - b) : b;
        neg  <= sgn_in && (a[63] ^ b[63]);
      end else if (busy) begin
        if (cnt < 3'd4) begin
          pp     <= a_part * b_part;
          pp_off <= 2'(cnt[1]) + 2'(cnt[0]);
        end
        if (cnt != 3'd0 && cnt <= 3'd4) begin
          acc <= acc + pp_sh;
        end
        if (cnt == 3'd5) begin
          res  <= neg ? (64'd0 - mag) : mag;
          done <= 1'b1;
          busy <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/tpr_div.sv =====
// Shared restoring divider: 128-bit dividend over a 64-bit divisor, one
// quotient bit per cycle. The quotient must fit 64 bits. Uses tpr_pkg.
module tpr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num_hi,
  input  logic [63:0] num_lo,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  import tpr_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] d;
  logic [64:0] trial;
  logic        ge;

  assign trial = {rem, quot[63]};
  assign ge    = (trial >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= num_hi;
        quot <= num_lo;
        d    <= den;
      end else if (busy) begin
        rem  <= ge ? 64'(trial - {1'b0, d}) : trial[63:0];
        quot <= {quot[62:0], ge};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
